### hdl/lrbs_pkg.sv
// Shared types and constants for the latching relay bank sequencer.
package lrbs_pkg;

    localparam int RelayCount = 18;
    localparam int IdxW       = 5;
    localparam int CoilW      = 6;
    localparam int ClGroup    = 8;

    localparam logic [IdxW-1:0]  LastRelay  = IdxW'(RelayCount - 1);
    localparam logic [IdxW-1:0]  C5Relay    = IdxW'(5);
    localparam logic [IdxW-1:0]  RelayV     = IdxW'(16);
    localparam logic [IdxW-1:0]  RelayH     = IdxW'(17);
    localparam logic [CoilW-1:0] C5SetCoil  = CoilW'(34);
    localparam logic [CoilW-1:0] ChainLimit = CoilW'(24);

    typedef logic [RelayCount-1:0] relay_vec_t;

    typedef enum logic [2:0] {
        CMD_SET_C   = 3'd0,
        CMD_SET_L   = 3'd1,
        CMD_SET_V   = 3'd2,
        CMD_SET_H   = 3'd3,
        CMD_LOAD    = 3'd4,
        CMD_PRESET  = 3'd5
    } cmd_t;

    typedef struct packed {
        relay_vec_t desired;
        logic       scan;
    } cmd_ctl_t;

    typedef struct packed {
        logic [CoilW-1:0] coil;
        logic             via_shift_chain;
    } coil_info_t;

endpackage

### hdl/lrbs_cmd_dec.sv
// Command decode: next desired vector and scan request for one command.
module lrbs_cmd_dec (
    input  logic [2:0]           cmd,
    input  logic [2:0]           relay_index,
    input  logic                 level,
    input  lrbs_pkg::relay_vec_t pattern,
    input  lrbs_pkg::relay_vec_t desired,
    output lrbs_pkg::cmd_ctl_t   ctl
);
    import lrbs_pkg::*;

    relay_vec_t d;
    logic       scan;

    always_comb
    begin
        d    = desired;
        scan = 1'b1;
        unique case (cmd)
            CMD_SET_C:
            begin
                d[{2'b00, relay_index}] = level;
            end
            CMD_SET_L:
            begin
                d[{2'b01, relay_index}] = level;
            end
            CMD_SET_V:
            begin
                d[RelayV] = level;
                if (level)
                begin
                    d[RelayH] = 1'b0;
                end
            end
            CMD_SET_H:
            begin
                d[RelayH] = level;
                if (level)
                begin
                    d[RelayV] = 1'b0;
                end
            end
            CMD_LOAD:
            begin
                d = pattern;
            end
            CMD_PRESET:
            begin
                scan = 1'b0;
            end
            default:
            begin
                d = desired;
            end
        endcase
    end

    assign ctl.desired = d;
    assign ctl.scan    = scan;

endmodule

### hdl/lrbs_coil_map.sv
// Coil map: relay index and level to coil line and drive path.
module lrbs_coil_map (
    input  logic [lrbs_pkg::IdxW-1:0] relay,
    input  logic                      level,
    output lrbs_pkg::coil_info_t      info
);
    import lrbs_pkg::*;

    logic [CoilW-1:0] set_coil;
    logic [CoilW-1:0] coil;

    always_comb
    begin
        priority if (relay == C5Relay)
        begin
            set_coil = C5SetCoil;
        end
        else if (relay > C5Relay)
        begin
            set_coil = {relay, 1'b0} - CoilW'(2);
        end
        else
        begin
            set_coil = {relay, 1'b0};
        end
        coil = set_coil + {{(CoilW-1){1'b0}}, ~level};
    end

    assign info.coil            = coil;
    assign info.via_shift_chain = (coil < ChainLimit);

endmodule

### hdl/latching_relay_bank_sequencer_core.sv
// Top level: command intake, relay scan sequencer and pulse event output register.
// An item is taken while idle; the scan then visits relays 0..17, one per cycle unless a pulse
// event waits on a full output register. No new command is taken until the scan ends;
// preset loads the applied vector without a scan.
// The scan loop steps a single coil map unit over the relays; output register stalls it.
// Reset: rst_n asynchronous, active low; desired and applied vectors clear to zero.
module latching_relay_bank_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // relay_index[2:0], level[3], pattern[21:4], zero[23:22]
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // coil[5:0], relay_number[10:6], new_level[11],
                                       // via_shift_chain[12], zero[15:13]
    output logic        m_axis_tlast   // last
);
    import lrbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    relay_vec_t       desired_reg, desired_next;
    relay_vec_t       applied_reg, applied_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [CoilW-1:0] coil_reg, coil_next;
    logic [IdxW-1:0]  relay_reg, relay_next;
    logic             level_reg, level_next;
    logic             via_reg, via_next;
    logic             last_reg, last_next;

    cmd_ctl_t   ctl;
    coil_info_t info;
    relay_vec_t diff;
    relay_vec_t above_mask;
    logic       req_take;
    logic       slot_free;
    logic       cur_diff;
    logic       more;

    lrbs_cmd_dec u_cmd_dec (
        .cmd         (s_axis_tuser),
        .relay_index (s_axis_tdata[2:0]),
        .level       (s_axis_tdata[3]),
        .pattern     (s_axis_tdata[21:4]),
        .desired     (desired_reg),
        .ctl         (ctl)
    );

    lrbs_coil_map u_coil_map (
        .relay (idx_reg),
        .level (desired_reg[idx_reg]),
        .info  (info)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign diff          = desired_reg ^ applied_reg;
    assign cur_diff      = diff[idx_reg];
    assign above_mask    = ~((relay_vec_t'(2) << idx_reg) - relay_vec_t'(1));
    assign more          = |(diff & above_mask);

    always_comb
    begin
        state_next     = state_reg;
        desired_next   = desired_reg;
        applied_next   = applied_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        coil_next      = coil_reg;
        relay_next     = relay_reg;
        level_next     = level_reg;
        via_next       = via_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    desired_next = ctl.desired;
                    idx_next     = '0;
                    if (ctl.scan)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        applied_next = s_axis_tdata[21:4];
                    end
                end
            end
            ST_SCAN:
            begin
                if (!cur_diff || slot_free)
                begin
                    if (cur_diff)
                    begin
                        applied_next[idx_reg] = desired_reg[idx_reg];
                        out_valid_next        = 1'b1;
                        coil_next             = info.coil;
                        relay_next            = idx_reg;
                        level_next            = desired_reg[idx_reg];
                        via_next              = info.via_shift_chain;
                        last_next             = !more;
                    end
                    if (idx_reg == LastRelay)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            desired_reg   <= '0;
            applied_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            desired_reg   <= desired_next;
            applied_reg   <= applied_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coil_reg  <= coil_next;
        relay_reg <= relay_next;
        level_reg <= level_next;
        via_reg   <= via_next;
        last_reg  <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, via_reg, level_reg, relay_reg, coil_reg};
    assign m_axis_tlast  = last_reg;

endmodule

### tb/relay_pulse_checker.sv
// Checker for the relay bank sequencer: predicts coil pulse events and compares every result.
`timescale 1ns / 100ps
module relay_pulse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // relay_index[2:0], level[3], pattern[21:4], zero[23:22]
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // coil[5:0], relay_number[10:6], new_level[11],
                                        // via_shift_chain[12], zero[15:13]
    input  logic        m_axis_tlast,   // last
    output int          failures,
    output int          pending
);
    import lrbs_pkg::*;

    typedef struct packed {
        logic [CoilW-1:0] coil;
        logic [IdxW-1:0]  relay;
        logic             level;
        logic             chain;
        logic             last;
    } pulse_t;

    relay_vec_t desired_relays = '0;
    relay_vec_t applied_relays = '0;
    pulse_t     pulses_due[$];
    int         fail_cnt = 0;

    assign failures = fail_cnt;

    task automatic report(input string what);
        fail_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [CoilW-1:0] pull_in_coil(input int relay);
        if (relay == int'(C5Relay))
            return C5SetCoil;
        if (relay >= 6)
            return CoilW'(2 * relay - 2);
        return CoilW'(2 * relay);
    endfunction

    // Update the desired/applied vectors for one request and queue the pulses it causes.
    task automatic take_request(input logic [2:0] op, input logic [2:0] idx,
                                input logic lvl, input relay_vec_t pat);
        relay_vec_t diff;
        pulse_t     p;
        case (op)
            CMD_SET_C:
                desired_relays[idx] = lvl;
            CMD_SET_L:
                desired_relays[int'(idx) + ClGroup] = lvl;
            CMD_SET_V:
            begin
                desired_relays[RelayV] = lvl;
                if (lvl)
                    desired_relays[RelayH] = 1'b0;
            end
            CMD_SET_H:
            begin
                desired_relays[RelayH] = lvl;
                if (lvl)
                    desired_relays[RelayV] = 1'b0;
            end
            CMD_LOAD:
                desired_relays = pat;
            CMD_PRESET:
            begin
                applied_relays = pat;
                return;
            end
            default:
                ;
        endcase
        diff = desired_relays ^ applied_relays;
        for (int i = 0; i < RelayCount; i++)
        begin
            if (diff[i])
            begin
                p.coil  = pull_in_coil(i) + (desired_relays[i] ? 1'b0 : 1'b1);
                p.relay = IdxW'(i);
                p.level = desired_relays[i];
                p.chain = (p.coil < ChainLimit);
                p.last  = ((diff >> (i + 1)) == '0);
                pulses_due.push_back(p);
                applied_relays[i] = desired_relays[i];
            end
        end
    endtask

    task automatic check_result();
        pulse_t want;
        if (pulses_due.size() == 0)
        begin
            report($sformatf("unexpected pulse event, tdata 0x%h", m_axis_tdata));
            return;
        end
        want = pulses_due.pop_front();
        if (m_axis_tdata[5:0] !== want.coil)
            report($sformatf("coil got %0d want %0d", m_axis_tdata[5:0], want.coil));
        if (m_axis_tdata[10:6] !== want.relay)
            report($sformatf("relay got %0d want %0d", m_axis_tdata[10:6], want.relay));
        if (m_axis_tdata[11] !== want.level)
            report($sformatf("relay %0d level got %b want %b", want.relay,
                             m_axis_tdata[11], want.level));
        if (m_axis_tdata[12] !== want.chain)
            report($sformatf("relay %0d shift chain flag got %b want %b", want.relay,
                             m_axis_tdata[12], want.chain));
        if (m_axis_tlast !== want.last)
            report($sformatf("relay %0d tlast got %b want %b", want.relay,
                             m_axis_tlast, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desired_relays = '0;
            applied_relays = '0;
            pulses_due.delete();
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_request(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[3],
                             s_axis_tdata[21:4]);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            pending <= pulses_due.size();
        end
    end

endmodule

### tb/latching_relay_bank_sequencer_core_tb.sv
// Testbench top for the relay bank sequencer: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module latching_relay_bank_sequencer_core_tb;
    import lrbs_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int         HOLD_AT      = 150;
    localparam int         HOLD_CYCLES  = 300;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata   = '0;
    logic [2:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    int failures;
    int pending;
    int s_idle_pct = 33;
    int r_idle_pct = 59;
    int sent_cnt   = 0;
    bit held       = 1'b0;

    latching_relay_bank_sequencer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    relay_pulse_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!held && sent_cnt >= HOLD_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    task automatic send_req(input logic [2:0] op, input logic [2:0] idx,
                            input logic lvl, input relay_vec_t pat);
        while ($urandom_range(99) < s_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, pat, lvl, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_cnt++;
    endtask

    task automatic random_burst(input int count);
        int         pick;
        logic [2:0] op;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                op = CMD_SET_C;
            else if (pick < 48)
                op = CMD_SET_L;
            else if (pick < 56)
                op = CMD_SET_V;
            else if (pick < 64)
                op = CMD_SET_H;
            else if (pick < 83)
                op = CMD_LOAD;
            else if (pick < 95)
                op = CMD_PRESET;
            else
                op = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            send_req(op, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     RelayCount'($urandom_range(18'h3FFFF)));
        end
    endtask

    // Hold the sender until every predicted pulse has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(CMD_SET_C,    3'd0, 1'b1, '0);
        send_req(CMD_SET_C,    3'd7, 1'b1, '0);
        send_req(CMD_SET_C,    3'd5, 1'b1, '0);
        send_req(CMD_SET_C,    3'd5, 1'b1, '1);   // already set: no pulse
        send_req(CMD_SET_L,    3'd0, 1'b1, '0);
        send_req(CMD_SET_L,    3'd7, 1'b1, '0);
        send_req(CMD_SET_V,    3'd7, 1'b1, '0);
        send_req(CMD_SET_H,    3'd0, 1'b1, '0);   // clears V
        send_req(CMD_SET_V,    3'd0, 1'b0, '0);
        send_req(CMD_SET_H,    3'd0, 1'b0, '0);
        send_req(CMD_SET_V,    3'd0, 1'b1, '0);
        send_req(CMD_SET_H,    3'd0, 1'b0, '0);   // level 0 leaves V alone
        send_req(CMD_LOAD,     3'd0, 1'b0, 18'h3FFFF);
        send_req(CMD_SET_C,    3'd0, 1'b0, '0);
        send_req(CMD_LOAD,     3'd0, 1'b0, 18'h00000);
        send_req(CMD_PRESET,   3'd0, 1'b0, 18'h3FFFF);
        send_req(CMD_SPARE_LO, 3'd0, 1'b0, '0);   // releases everything preset
        send_req(CMD_PRESET,   3'd0, 1'b0, 18'h15555);
        send_req(CMD_SPARE_HI, 3'd7, 1'b1, 18'h3FFFF);
        send_req(CMD_LOAD,     3'd0, 1'b0, 18'h2AAAA);
        send_req(CMD_PRESET,   3'd0, 1'b0, 18'h00000);
        send_req(CMD_LOAD,     3'd0, 1'b0, 18'h2AAAA);
        send_req(CMD_SET_L,    3'd3, 1'b0, '0);
        send_req(CMD_SET_C,    3'd6, 1'b1, '0);
        send_req(CMD_SET_L,    3'd4, 1'b1, '0);
        random_burst(60);
        drain();

        s_idle_pct = 59;
        r_idle_pct = 33;
        random_burst(60);
        drain();

        s_idle_pct = 0;
        r_idle_pct = 0;
        random_burst(60);
        drain();

        repeat (40) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/lrbs_pkg.sv
hdl/lrbs_cmd_dec.sv
hdl/lrbs_coil_map.sv
hdl/latching_relay_bank_sequencer_core.sv
tb/relay_pulse_checker.sv
tb/latching_relay_bank_sequencer_core_tb.sv
